@@ rtl/dscs_pkg.sv @@
package dscs_pkg;

  localparam logic [7:0] TagSeq       = 8'h30;
  localparam logic [7:0] LongFormBit  = 8'h80;
  localparam logic [7:0] LenValueMask = 8'h7F;
  localparam logic [6:0] LenBytes1    = 7'h01;
  localparam logic [6:0] LenBytes2    = 7'h02;
  localparam logic [6:0] LenBytes4    = 7'h04;

  localparam logic [2:0] PhTag     = 3'd0;
  localparam logic [2:0] PhLen     = 3'd1;
  localparam logic [2:0] PhLenExt  = 3'd2;
  localparam logic [2:0] PhContent = 3'd3;
  localparam logic [2:0] PhDrop    = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StNoTag  = 2'd1;
  localparam logic [1:0] StBadLen = 2'd2;
  localparam logic [1:0] StTrunc  = 2'd3;

  localparam logic [15:0] CertCntMax = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  len_left;
    logic [31:0] content_left;
    logic [15:0] cert_cnt;
    logic [1:0]  err;
  } state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        cert_start;
    logic        cert_end;
    logic [15:0] cert_index;
    logic        chain_done;
    logic [1:0]  status;
  } result_t;

endpackage

@@ rtl/dscs_step.sv @@
module dscs_step (
  input  dscs_pkg::state_t  state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_buffer_i,
  output dscs_pkg::state_t  state_o,
  output dscs_pkg::result_t result_o
);

  logic [6:0]  len_n;
  logic        finish;
  logic [31:0] cont_ext;
  logic [2:0]  left_dec;
  logic [31:0] cont_dec;

  always_comb begin
    len_n    = data_byte_i[6:0] & dscs_pkg::LenValueMask[6:0];
    cont_ext = {state_i.content_left[23:0], data_byte_i};
    left_dec = (state_i.len_left != 3'd0) ? state_i.len_left - 3'd1 : 3'd0;
    cont_dec = (state_i.content_left != 32'd0) ? state_i.content_left - 32'd1 : 32'd0;
    finish   = 1'b0;
    state_o  = state_i;
    result_o = '0;
    result_o.out_byte   = data_byte_i;
    result_o.cert_index = state_i.cert_cnt;
    result_o.chain_done = end_of_buffer_i;

    case (state_i.phase)
      dscs_pkg::PhTag: begin
        if (data_byte_i == dscs_pkg::TagSeq) begin
          result_o.byte_valid = 1'b1;
          result_o.cert_start = 1'b1;
          state_o.phase       = dscs_pkg::PhLen;
        end else begin
          state_o.err   = dscs_pkg::StNoTag;
          state_o.phase = dscs_pkg::PhDrop;
        end
      end
      dscs_pkg::PhLen: begin
        if ((data_byte_i & dscs_pkg::LongFormBit) == 8'h00) begin
          result_o.byte_valid  = 1'b1;
          state_o.content_left = {24'd0, data_byte_i};
          if (data_byte_i == 8'h00) begin
            finish = 1'b1;
          end else begin
            state_o.phase = dscs_pkg::PhContent;
          end
        end else if (len_n == dscs_pkg::LenBytes1 || len_n == dscs_pkg::LenBytes2 ||
                     len_n == dscs_pkg::LenBytes4) begin
          result_o.byte_valid  = 1'b1;
          state_o.len_left     = len_n[2:0];
          state_o.content_left = 32'd0;
          state_o.phase        = dscs_pkg::PhLenExt;
        end else begin
          state_o.err   = dscs_pkg::StBadLen;
          state_o.phase = dscs_pkg::PhDrop;
        end
      end
      dscs_pkg::PhLenExt: begin
        result_o.byte_valid  = 1'b1;
        state_o.content_left = cont_ext;
        state_o.len_left     = left_dec;
        if (left_dec == 3'd0) begin
          if (cont_ext == 32'd0) begin
            finish = 1'b1;
          end else begin
            state_o.phase = dscs_pkg::PhContent;
          end
        end
      end
      dscs_pkg::PhContent: begin
        result_o.byte_valid  = 1'b1;
        state_o.content_left = cont_dec;
        if (cont_dec == 32'd0) begin
          finish = 1'b1;
        end
      end
      default: begin
        state_o.phase = dscs_pkg::PhDrop;
      end
    endcase

    if (finish) begin
      result_o.cert_end = 1'b1;
      state_o.phase     = dscs_pkg::PhTag;
      if (state_i.cert_cnt != dscs_pkg::CertCntMax) begin
        state_o.cert_cnt = state_i.cert_cnt + 16'd1;
      end
    end

    result_o.status = state_o.err;
    if (end_of_buffer_i && state_o.err == dscs_pkg::StOk &&
        state_o.phase != dscs_pkg::PhTag) begin
      result_o.status = dscs_pkg::StTrunc;
    end

    if (end_of_buffer_i) begin
      state_o       = '0;
      state_o.phase = dscs_pkg::PhTag;
      state_o.err   = dscs_pkg::StOk;
    end
  end

endmodule

@@ rtl/der_sequence_chain_splitter_core.sv @@
// Splits a concatenated DER certificate chain, fed one byte per transaction,
// into SEQUENCE elements (tag 0x30, short or 1/2/4-byte long-form length).
// Input channel: data_byte_i and end_of_buffer_i under in_valid_i/in_ready_o.
// Output channel: one result per input byte under out_valid_o/out_ready_i,
// carrying the byte, valid/start/end flags, certificate index, chain_done
// and status (ok, missing tag, bad length form, truncated).
// Latency: the result appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle; parsing state and the result register
// update together, so a new byte is taken whenever the result register is
// empty or its result is taken in the same cycle.
// When the receiver stalls, the result is held and in_ready_o drops until
// it is taken. After an error, bytes are passed with byte_valid low until
// the byte marked end_of_buffer_i, after which parsing starts a new chain.
// Reset returns the parser to expecting a tag, index zero, no error, and
// empties the result register.
module der_sequence_chain_splitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        cert_start_o,
  output logic        cert_end_o,
  output logic [15:0] cert_index_o,
  output logic        chain_done_o,
  output logic [1:0]  status_o
);

  dscs_pkg::state_t  state_q, state_d;
  dscs_pkg::result_t res_q, res_d;
  logic              out_valid_q;
  logic              accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dscs_step u_step (
    .state_i         (state_q),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .state_o         (state_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: dscs_pkg::PhTag, len_left: 3'd0, content_left: 32'd0,
                       cert_cnt: 16'd0, err: dscs_pkg::StOk};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = res_q.out_byte;
  assign byte_valid_o = res_q.byte_valid;
  assign cert_start_o = res_q.cert_start;
  assign cert_end_o   = res_q.cert_end;
  assign cert_index_o = res_q.cert_index;
  assign chain_done_o = res_q.chain_done;
  assign status_o     = res_q.status;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

class chain_split_checker;
  dscs_pkg::result_t pending_results[$];
  logic [2:0]  phase;
  logic [2:0]  len_left;
  logic [31:0] content_left;
  logic [15:0] cert_cnt;
  logic [1:0]  err;
  int unsigned mismatches;

  function new();
    mismatches = 0;
    clear_chain();
  endfunction

  function void clear_chain();
    phase        = dscs_pkg::PhTag;
    len_left     = '0;
    content_left = '0;
    cert_cnt     = '0;
    err          = dscs_pkg::StOk;
  endfunction

  function void close_cert();
    if (cert_cnt != dscs_pkg::CertCntMax) cert_cnt = cert_cnt + 16'd1;
    phase = dscs_pkg::PhTag;
  endfunction

  // Accepted input transaction: advance the parser copy, queue the result.
  function void note_byte(logic [7:0] b, logic last);
    dscs_pkg::result_t exp;
    logic [6:0]        nlen;
    exp            = '0;
    exp.out_byte   = b;
    exp.cert_index = cert_cnt;
    exp.chain_done = last;
    nlen           = b[6:0] & dscs_pkg::LenValueMask[6:0];
    case (phase)
      dscs_pkg::PhTag: begin
        if (b == dscs_pkg::TagSeq) begin
          exp.byte_valid = 1'b1;
          exp.cert_start = 1'b1;
          phase          = dscs_pkg::PhLen;
        end else begin
          err   = dscs_pkg::StNoTag;
          phase = dscs_pkg::PhDrop;
        end
      end
      dscs_pkg::PhLen: begin
        if ((b & dscs_pkg::LongFormBit) == 8'h00) begin
          exp.byte_valid = 1'b1;
          content_left   = {24'h0, b};
          if (b == 8'h00) begin
            exp.cert_end = 1'b1;
            close_cert();
          end else begin
            phase = dscs_pkg::PhContent;
          end
        end else if (nlen == dscs_pkg::LenBytes1 || nlen == dscs_pkg::LenBytes2 ||
                     nlen == dscs_pkg::LenBytes4) begin
          exp.byte_valid = 1'b1;
          len_left       = nlen[2:0];
          content_left   = '0;
          phase          = dscs_pkg::PhLenExt;
        end else begin
          err   = dscs_pkg::StBadLen;
          phase = dscs_pkg::PhDrop;
        end
      end
      dscs_pkg::PhLenExt: begin
        exp.byte_valid = 1'b1;
        content_left   = {content_left[23:0], b};
        if (len_left != 3'd0) len_left = len_left - 3'd1;
        if (len_left == 3'd0) begin
          if (content_left == 32'd0) begin
            exp.cert_end = 1'b1;
            close_cert();
          end else begin
            phase = dscs_pkg::PhContent;
          end
        end
      end
      dscs_pkg::PhContent: begin
        exp.byte_valid = 1'b1;
        if (content_left != 32'd0) content_left = content_left - 32'd1;
        if (content_left == 32'd0) begin
          exp.cert_end = 1'b1;
          close_cert();
        end
      end
      default: phase = dscs_pkg::PhDrop;
    endcase
    exp.status = err;
    if (last && err == dscs_pkg::StOk && phase != dscs_pkg::PhTag) begin
      exp.status = dscs_pkg::StTrunc;
    end
    pending_results = {pending_results, exp};
    if (last) clear_chain();
  endfunction

  function void check_result(dscs_pkg::result_t got);
    dscs_pkg::result_t exp;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result expected none got %h", $time, got);
      mismatches++;
    end else begin
      exp = pending_results.pop_front();
      if (exp !== got) begin
        $display("%0t: result expected %h got %h", $time, exp, got);
        mismatches++;
      end
    end
  endfunction
endclass

module tb;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned PhaseBytes = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_buffer_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        cert_start_o;
  logic        cert_end_o;
  logic [15:0] cert_index_o;
  logic        chain_done_o;
  logic [1:0]  status_o;

  chain_split_checker split_check = new();
  logic [7:0]         chain_bytes[$];
  int unsigned        gap_pct;
  int unsigned        stall_pct;
  int unsigned        bytes_sent;
  int unsigned        cycles;

  der_sequence_chain_splitter_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_buffer_i(end_of_buffer_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .cert_start_o   (cert_start_o),
    .cert_end_o     (cert_end_o),
    .cert_index_o   (cert_index_o),
    .chain_done_o   (chain_done_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL der_sequence_chain_splitter_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin : rx_side
    dscs_pkg::result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_byte_o, byte_valid_o, cert_start_o, cert_end_o, cert_index_o,
             chain_done_o, status_o};
      split_check.check_result(got);
    end
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic put_byte(input logic [7:0] b);
    chain_bytes = {chain_bytes, b};
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_buffer_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    split_check.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_chain();
    for (int i = 0; i < chain_bytes.size(); i++) begin
      send_byte(chain_bytes[i], i == chain_bytes.size() - 1);
    end
  endtask

  // Sender holds off until every queued result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (split_check.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic add_cert(input int unsigned clen, input int unsigned nb);
    put_byte(dscs_pkg::TagSeq);
    if (nb == 0) begin
      put_byte(8'(clen));
    end else begin
      put_byte(dscs_pkg::LongFormBit | 8'(nb));
      for (int k = nb - 1; k >= 0; k--) put_byte(8'(clen >> (8 * k)));
    end
    repeat (clen) put_byte(8'($urandom_range(255)));
  endtask

  task automatic add_random_cert();
    int unsigned clen;
    int unsigned sel;
    int unsigned nb;
    sel = $urandom_range(99);
    if (sel < 65) clen = $urandom_range(8);
    else if (sel < 92) clen = $urandom_range(40, 9);
    else clen = $urandom_range(300, 41);
    case ($urandom_range(3))
      0: nb = 0;
      1: nb = 1;
      2: nb = 2;
      default: nb = 4;
    endcase
    if (clen > 127 && nb == 0) nb = 2;
    if (clen > 255 && nb == 1) nb = 2;
    add_cert(clen, nb);
  endtask

  task automatic add_defect();
    logic [7:0]  b;
    int unsigned nb;
    case ($urandom_range(3))
      0: begin
        do b = 8'($urandom_range(255)); while (b == dscs_pkg::TagSeq);
        put_byte(b);
        repeat ($urandom_range(5)) put_byte(8'($urandom_range(255)));
      end
      1: begin
        put_byte(dscs_pkg::TagSeq);
        do b = 8'($urandom_range(255, 128));
        while (b[6:0] == dscs_pkg::LenBytes1 || b[6:0] == dscs_pkg::LenBytes2 ||
               b[6:0] == dscs_pkg::LenBytes4);
        put_byte(b);
        repeat ($urandom_range(5)) put_byte(8'($urandom_range(255)));
      end
      2: begin
        // truncated element: cut after the tag, in the length, or in the content
        put_byte(dscs_pkg::TagSeq);
        case ($urandom_range(2))
          0: ;
          1: begin
            b = 8'($urandom_range(127, 1));
            put_byte(b);
            repeat ($urandom_range(b - 1)) put_byte(8'($urandom_range(255)));
          end
          default: begin
            nb = 1 << $urandom_range(2);
            put_byte(dscs_pkg::LongFormBit | 8'(nb));
            repeat ($urandom_range(nb, 1)) put_byte(8'($urandom_range(255)));
            repeat ($urandom_range(3)) put_byte(8'($urandom_range(255)));
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(8, 1)) put_byte(8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic build_random_chain();
    chain_bytes.delete();
    if ($urandom_range(99) < 70) begin
      repeat ($urandom_range(4, 1)) add_random_cert();
    end else begin
      repeat ($urandom_range(2)) add_random_cert();
      add_defect();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_buffer_i = 1'b0;
    gap_pct         = 0;
    stall_pct       = 0;
    bytes_sent      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length short form, 0x81 with zero content, 0x84 with one byte
    chain_bytes = '{8'h30, 8'h00, 8'h30, 8'h81, 8'h00,
                    8'h30, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_chain();
    chain_bytes = '{8'h30, 8'h80};
    send_chain();
    chain_bytes = '{8'h00};
    send_chain();
    chain_bytes = '{8'h30, 8'h05, 8'h01};
    send_chain();
    chain_bytes = '{8'h30, 8'h02, 8'hAB, 8'h31, 8'h30, 8'h00};
    send_chain();
    chain_bytes = '{8'h30, 8'hFF, 8'h12};
    send_chain();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 86; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 86; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      bytes_sent = 0;
      while (bytes_sent < PhaseBytes) begin
        build_random_chain();
        send_chain();
      end
      drain();
    end

    gap_pct   = 0;
    stall_pct = 0;
    drain();
    if (split_check.mismatches == 0 && split_check.pending_results.size() == 0) begin
      $display("PASS der_sequence_chain_splitter_core");
    end else begin
      $display("FAIL der_sequence_chain_splitter_core");
    end
    $finish;
  end

endmodule
